### hw/rtl/uer_pkg.sv
// Package for the ultrasonic echo ranger: shared types, register codes and constants.
// No dependencies; all other design files of the block but uer_chk use it by scoped names.
`timescale 1ns / 1ps

package uer_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int SAMPLE_W       = 16;
    localparam int SCALE_W        = 19;

    localparam logic [SCALE_W-1:0] DIST_SCALE = 19'd287733;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 2'd1;

    localparam logic [15:0] TIMEOUT_RST = 16'd13200;
    localparam logic [7:0]  TRIGGER_RST = 8'd10;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_TRIG = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_HIGH = 4'b1000
    } t_phase;

    typedef struct packed {
        logic                trig;
        logic                busy;
        logic                done;
        logic [SAMPLE_W-1:0] s0;
        logic [SAMPLE_W-1:0] s1;
        logic [SAMPLE_W-1:0] s2;
    } t_item;

endpackage

### hw/rtl/uer_if.sv
// Channel interfaces of the ranger: tick input, result output and register writes.
// Depends on uer_pkg for widths.
`timescale 1ns / 1ps

interface uer_tick_if;
    logic valid;
    logic ready;
    logic echo_level;
    logic start_req;
    modport source (output valid, output echo_level, output start_req, input ready);
    modport sink   (input valid, input echo_level, input start_req, output ready);
endinterface

interface uer_res_if;
    logic        valid;
    logic        ready;
    logic        trigger_out;
    logic        busy_res;
    logic        result_valid;
    logic [15:0] median_width;
    logic [15:0] distance_q8;
    modport source (output valid, output trigger_out, output busy_res, output result_valid,
                    output median_width, output distance_q8, input ready);
    modport sink   (input valid, input trigger_out, input busy_res, input result_valid,
                    input median_width, input distance_q8, output ready);
endinterface

interface uer_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [uer_pkg::CFG_IDX_W-1:0]  index;
    logic [uer_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/uer_front.sv
// Front of the ranger: configuration registers and the per-tick measurement sequencer.
// Depends on uer_pkg and uer_if; emits one t_item per accepted tick.
`timescale 1ns / 1ps

module uer_front #(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    uer_tick_if.sink       i_tick,
    uer_cfg_if.sink        i_cfg,
    input  logic           i_q_full,
    output logic           o_push,
    output uer_pkg::t_item o_item
);

    localparam int W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    uer_pkg::t_phase        r_phase, n_phase, ph;
    logic [COUNT_BITS-1:0]  r_elapsed, n_elapsed, el, el1;
    logic [COUNT_BITS-1:0]  r_width, n_width, wc, wc1;
    logic [1:0]             r_idx, n_idx, ix, fidx;
    logic [15:0]            r_timeout;
    logic [7:0]             r_trig_len;
    logic [7:0]             len;
    logic [15:0]            r_store [2];
    logic                   fin;
    logic [COUNT_BITS-1:0]  fin_w;
    logic [15:0]            fin_clamp;
    logic                   tmo;
    logic                   trig, busy, done;

    assign i_tick.ready = !i_q_full;
    assign i_cfg.ready  = 1'b1;
    assign o_push       = i_tick.valid && !i_q_full;

    always_comb begin
        ph = r_phase;
        el = r_elapsed;
        wc = r_width;
        ix = r_idx;
        if (r_phase == uer_pkg::PH_IDLE && i_tick.start_req) begin
            ph = uer_pkg::PH_TRIG;
            el = '0;
            wc = '0;
            ix = '0;
        end
        el1 = (el == CNT_MAX) ? el : el + 1'b1;
        wc1 = (wc == CNT_MAX) ? wc : wc + 1'b1;
        len = (r_trig_len == 8'd0) ? 8'd1 : r_trig_len;
        tmo = (W'(el1) > W'(r_timeout)) || (el1 == CNT_MAX);

        n_phase   = ph;
        n_elapsed = el;
        n_width   = wc;
        n_idx     = ix;
        trig      = 1'b0;
        busy      = 1'b0;
        done      = 1'b0;
        fin       = 1'b0;
        fin_w     = '0;

        unique case (ph)
            uer_pkg::PH_TRIG: begin
                trig = 1'b1;
                busy = 1'b1;
                if (el1 >= COUNT_BITS'(len)) begin
                    n_elapsed = '0;
                    n_phase   = uer_pkg::PH_WAIT;
                end else begin
                    n_elapsed = el1;
                end
            end
            uer_pkg::PH_WAIT: begin
                busy = 1'b1;
                if (i_tick.echo_level) begin
                    n_width   = COUNT_BITS'(1);
                    n_elapsed = el1;
                    n_phase   = uer_pkg::PH_HIGH;
                end else if (tmo) begin
                    fin = 1'b1;
                end else begin
                    n_elapsed = el1;
                end
            end
            uer_pkg::PH_HIGH: begin
                busy = 1'b1;
                if (i_tick.echo_level) begin
                    if (tmo) begin
                        fin = 1'b1;
                    end else begin
                        n_width   = wc1;
                        n_elapsed = el1;
                    end
                end else begin
                    fin   = 1'b1;
                    fin_w = wc;
                end
            end
            default: begin
                n_phase = uer_pkg::PH_IDLE;
            end
        endcase

        fidx = (ix == 2'd3) ? 2'd2 : ix;
        if (fin) begin
            n_elapsed = '0;
            n_width   = '0;
            if (fidx == 2'd2) begin
                n_idx   = 2'd0;
                n_phase = uer_pkg::PH_IDLE;
                done    = 1'b1;
            end else begin
                n_idx   = fidx + 2'd1;
                n_phase = uer_pkg::PH_TRIG;
            end
        end
        fin_clamp = (W'(fin_w) > W'(16'hFFFF)) ? 16'hFFFF : 16'(fin_w);

        o_item.trig = trig;
        o_item.busy = busy;
        o_item.done = done;
        o_item.s0   = r_store[0];
        o_item.s1   = r_store[1];
        o_item.s2   = fin_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= uer_pkg::PH_IDLE;
            r_elapsed  <= '0;
            r_width    <= '0;
            r_idx      <= '0;
            r_timeout  <= uer_pkg::TIMEOUT_RST;
            r_trig_len <= uer_pkg::TRIGGER_RST;
        end else begin
            if (o_push) begin
                r_phase   <= n_phase;
                r_elapsed <= n_elapsed;
                r_width   <= n_width;
                r_idx     <= n_idx;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    uer_pkg::REG_TIMEOUT: r_timeout  <= i_cfg.data;
                    uer_pkg::REG_TRIGGER: r_trig_len <= i_cfg.data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push && fin && fidx != 2'd2) begin
            r_store[fidx[0]] <= fin_clamp;
        end
    end

endmodule

### hw/rtl/uer_fifo.sv
// Short queue of t_item between front and back of the ranger.
// Depends on uer_pkg for the item type and depth.
`timescale 1ns / 1ps

module uer_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  uer_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_vld,
    output uer_pkg::t_item o_item
);

    localparam int PW = $clog2(uer_pkg::QUEUE_DEPTH);

    uer_pkg::t_item r_mem [uer_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [PW:0]    r_cnt;

    assign o_full = (r_cnt == (PW+1)'(uer_pkg::QUEUE_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_item = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

### hw/rtl/uer_back.sv
// Back of the ranger: median of three, then distance scaling into the result register.
// Depends on uer_pkg and uer_if; pops items from uer_fifo.
`timescale 1ns / 1ps

module uer_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_vld,
    input  uer_pkg::t_item i_item,
    output logic           o_pop,
    uer_res_if.source      o_res
);

    logic        r_a_vld, r_a_trig, r_a_busy, r_a_done;
    logic [15:0] r_a_med;
    logic        r_b_vld, r_b_trig, r_b_busy, r_b_done;
    logic [15:0] r_b_med, r_b_dist;
    logic        b_free, a_free;
    logic [15:0] lo, hi, mid;
    logic [34:0] prod;
    logic [18:0] scaled;
    logic [15:0] dist_sat;

    assign b_free = !r_b_vld || o_res.ready;
    assign a_free = !r_a_vld || b_free;
    assign o_pop  = i_q_vld && a_free;

    always_comb begin
        lo       = (i_item.s0 < i_item.s1) ? i_item.s0 : i_item.s1;
        hi       = (i_item.s0 < i_item.s1) ? i_item.s1 : i_item.s0;
        mid      = (hi < i_item.s2) ? hi : i_item.s2;
        mid      = (lo > mid) ? lo : mid;
        prod     = 35'(r_a_med) * 35'(uer_pkg::DIST_SCALE);
        scaled   = prod[34:16];
        dist_sat = (scaled[18:16] != 3'd0) ? 16'hFFFF : scaled[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_vld <= i_q_vld;
            end
            if (b_free) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free) begin
            r_a_trig <= i_item.trig;
            r_a_busy <= i_item.busy;
            r_a_done <= i_item.done;
            r_a_med  <= i_item.done ? mid : 16'd0;
        end
        if (b_free) begin
            r_b_trig <= r_a_trig;
            r_b_busy <= r_a_busy;
            r_b_done <= r_a_done;
            r_b_med  <= r_a_med;
            r_b_dist <= r_a_done ? dist_sat : 16'd0;
        end
    end

    assign o_res.valid        = r_b_vld;
    assign o_res.trigger_out  = r_b_trig;
    assign o_res.busy_res     = r_b_busy;
    assign o_res.result_valid = r_b_done;
    assign o_res.median_width = r_b_med;
    assign o_res.distance_q8  = r_b_dist;

endmodule

### hw/rtl/ultrasonic_echo_ranger_median3.sv
// Top level of the ultrasonic echo ranger with median-of-three filtering.
// Depends on uer_pkg, uer_if, uer_front, uer_fifo and uer_back.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+-------------------------------------------
//   i_tick   | in  | i_tick.valid/ready     | echo_level, start_req
//   o_res    | out | o_res.valid/ready      | trigger_out, busy_res, result_valid,
//            |     |                        | median_width, distance_q8
//   i_cfg    | in  | i_cfg.valid/ready      | index (0 timeout_ticks, 1 trigger_ticks), data
//
// One tick accepted per cycle while the queue has room; each tick yields one result on o_res,
// passing from the sequencer into the queue, then the median stage, then the scaling
// multiplier into the output register.
// A four-entry queue parts the sequencer from the result stages; ticks stall only
// when it is full. Config writes are taken every cycle. Reset is synchronous,
// active low, and clears control state only.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_median3 #(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    uer_tick_if.sink  i_tick,
    uer_cfg_if.sink   i_cfg,
    uer_res_if.source o_res
);

    logic           push, pop, q_full, q_vld;
    uer_pkg::t_item f_item, q_item;

    uer_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (i_tick),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (f_item)
    );

    uer_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_item  (q_item)
    );

    uer_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_vld (q_vld),
        .i_item  (q_item),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

### hw/rtl/uer_chk.sv
// Port-level checker for the ranger result channel, bound to the top level.
// Depends on ultrasonic_echo_ranger_median3 for the bind target.
`timescale 1ns / 1ps

module uer_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic        i_trigger_out,
    input logic        i_busy_res,
    input logic        i_result_valid,
    input logic [15:0] i_median_width,
    input logic [15:0] i_distance_q8
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_median_width)
            && $stable(i_distance_q8) && $stable(i_result_valid))
        else $error("result transaction dropped or changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_result_valid || i_trigger_out) |-> i_busy_res)
        else $error("trigger or result outside a busy burst");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_result_valid |-> i_median_width == 16'd0 && i_distance_q8 == 16'd0)
        else $error("nonzero median or distance without a result");

    a_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_median_width == 16'd0 |-> i_distance_q8 == 16'd0)
        else $error("distance nonzero for a zero width");

endmodule

bind ultrasonic_echo_ranger_median3 uer_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_trigger_out  (o_res.trigger_out),
    .i_busy_res     (o_res.busy_res),
    .i_result_valid (o_res.result_valid),
    .i_median_width (o_res.median_width),
    .i_distance_q8  (o_res.distance_q8)
);

### test/uer_checker.sv
// Checker for the ultrasonic echo ranger: watches the tick, register and result channels,
// predicts every result from the accepted ticks and compares them in order.
// Depends on uer_pkg and uer_if; reports its failure count to tb_top.
`timescale 1ns / 1ps

module uer_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    uer_tick_if  i_tick,
    uer_cfg_if   i_cfg,
    uer_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output logic o_idle
);

    localparam logic [15:0] COUNT_TOP  = 16'hFFFF;
    localparam int          SHOW_LIMIT = 10;

    typedef struct packed {
        logic        trig;
        logic        busy;
        logic        valid;
        logic [15:0] med;
        logic [15:0] dist_q8;
    } t_echo_result;

    logic [15:0]     timeout_ticks;
    logic [7:0]      trigger_ticks;
    uer_pkg::t_phase phase;
    logic [15:0]     elapsed;
    logic [15:0]     echo_width;
    logic [1:0]      sample_idx;
    logic [15:0]     samples [3];
    t_echo_result    results_due [$];
    int              fails;

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == COUNT_TOP) ? v : v + 16'd1;
    endfunction

    function automatic logic [15:0] middle_of(input logic [15:0] a, input logic [15:0] b,
                                              input logic [15:0] c);
        logic [15:0] lo;
        logic [15:0] hi;
        lo = a;
        hi = b;
        if (lo > hi) begin
            lo = b;
            hi = a;
        end
        if (hi > c) begin
            hi = c;
        end
        return (lo > hi) ? lo : hi;
    endfunction

    function automatic logic store_sample(input logic [15:0] w);
        logic [1:0] slot;
        slot = (sample_idx > 2'd2) ? 2'd2 : sample_idx;
        samples[slot] = w;
        elapsed = '0;
        echo_width = '0;
        if (slot == 2'd2) begin
            sample_idx = '0;
            phase = uer_pkg::PH_IDLE;
            return 1'b1;
        end
        sample_idx = slot + 2'd1;
        phase = uer_pkg::PH_TRIG;
        return 1'b0;
    endfunction

    function automatic t_echo_result range_tick(input logic echo, input logic start);
        t_echo_result    r;
        uer_pkg::t_phase ph;
        logic [7:0]      trig_len;
        logic            done;
        logic [34:0]     scaled;
        r = '0;
        done = 1'b0;
        ph = phase;
        trig_len = (trigger_ticks == 8'd0) ? 8'd1 : trigger_ticks;
        if (ph == uer_pkg::PH_IDLE && start) begin
            ph = uer_pkg::PH_TRIG;
            elapsed = '0;
            echo_width = '0;
            sample_idx = '0;
        end
        case (ph)
            uer_pkg::PH_TRIG: begin
                r.busy = 1'b1;
                r.trig = 1'b1;
                elapsed = bump(elapsed);
                if (elapsed >= 16'(trig_len)) begin
                    elapsed = '0;
                    ph = uer_pkg::PH_WAIT;
                end
                phase = ph;
            end
            uer_pkg::PH_WAIT: begin
                r.busy = 1'b1;
                elapsed = bump(elapsed);
                if (echo) begin
                    echo_width = 16'd1;
                    phase = uer_pkg::PH_HIGH;
                end else if (elapsed > timeout_ticks || elapsed == COUNT_TOP) begin
                    done = store_sample('0);
                end
            end
            uer_pkg::PH_HIGH: begin
                r.busy = 1'b1;
                elapsed = bump(elapsed);
                if (echo) begin
                    echo_width = bump(echo_width);
                    if (elapsed > timeout_ticks || elapsed == COUNT_TOP) begin
                        done = store_sample('0);
                    end
                end else begin
                    done = store_sample(echo_width);
                end
            end
            default: begin
                phase = uer_pkg::PH_IDLE;
            end
        endcase
        if (done) begin
            r.valid = 1'b1;
            r.med = middle_of(samples[0], samples[1], samples[2]);
            scaled = 35'(r.med) * 35'(uer_pkg::DIST_SCALE);
            r.dist_q8 = (scaled[34:16] > 19'd65535) ? 16'hFFFF : scaled[31:16];
        end
        return r;
    endfunction

    task automatic flag_result(input string what, input t_echo_result want,
                               input t_echo_result seen);
        fails++;
        if (fails <= SHOW_LIMIT) begin
            $display("%0t %s: exp trig=%0b busy=%0b valid=%0b med=%0d dist=%0d", $time, what,
                     want.trig, want.busy, want.valid, want.med, want.dist_q8);
            $display("%0t %s: got trig=%0b busy=%0b valid=%0b med=%0d dist=%0d", $time, what,
                     seen.trig, seen.busy, seen.valid, seen.med, seen.dist_q8);
        end
    endtask

    always @(posedge i_clk) begin
        t_echo_result seen;
        t_echo_result want;
        if (!i_rst_n) begin
            timeout_ticks = uer_pkg::TIMEOUT_RST;
            trigger_ticks = uer_pkg::TRIGGER_RST;
            phase = uer_pkg::PH_IDLE;
            elapsed = '0;
            echo_width = '0;
            sample_idx = '0;
            samples[0] = '0;
            samples[1] = '0;
            samples[2] = '0;
            results_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == uer_pkg::REG_TIMEOUT) begin
                    timeout_ticks = i_cfg.data;
                end else if (i_cfg.index == uer_pkg::REG_TRIGGER) begin
                    trigger_ticks = i_cfg.data[7:0];
                end
            end
            if (i_res.valid && i_res.ready) begin
                seen.trig    = i_res.trigger_out;
                seen.busy    = i_res.busy_res;
                seen.valid   = i_res.result_valid;
                seen.med     = i_res.median_width;
                seen.dist_q8 = i_res.distance_q8;
                if (results_due.size() == 0) begin
                    flag_result("unexpected transaction", '0, seen);
                end else begin
                    want = results_due.pop_front();
                    if (seen !== want) begin
                        flag_result("mismatch", want, seen);
                    end
                end
            end
            if (i_tick.valid && i_tick.ready) begin
                results_due.push_back(range_tick(i_tick.echo_level, i_tick.start_req));
            end
        end
        o_fail_count <= fails;
        o_pending    <= results_due.size();
        o_idle       <= (phase == uer_pkg::PH_IDLE);
    end

    initial begin
        fails = 0;
        o_fail_count = 0;
        o_pending = 0;
        o_idle = 1'b1;
    end

endmodule

### test/tb_top.sv
// Top of the echo ranger testbench: clock, reset, tick and register stimulus, result stalls.
// Depends on uer_pkg, uer_if, the ranger RTL and uer_checker, which checks the results.
`timescale 1ns / 1ps

module tb_top;

    localparam int HALF_PERIOD   = 10;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_TICKS   = 190;
    localparam int NUM_PHASES    = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int DIRECTED_LEN  = 26;

    localparam logic [uer_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // bit i is tick i: timeout in wait, timeout while high, echo at the timeout tick,
    // start while busy, then a short burst with a nonzero median
    localparam logic [DIRECTED_LEN-1:0] DIR_ECHO  = 26'b01_0011_0010_1100_0100_0000_1101;
    localparam logic [DIRECTED_LEN-1:0] DIR_START = 26'b00_0000_0001_0000_0000_0000_0110;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic [15:0] ready_pat = 16'hFFFF;
    logic [3:0]  ready_pos = '0;
    int          cycle_count = 0;
    int          fail_count;
    int          pending;
    logic        chk_idle;
    int          gap_max;
    int          span;
    logic        echo_lvl;
    int          echo_run;

    uer_tick_if tick_bus ();
    uer_cfg_if  cfg_bus ();
    uer_res_if  res_bus ();

    ultrasonic_echo_ranger_median3 u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_bus),
        .i_cfg   (cfg_bus),
        .o_res   (res_bus)
    );

    uer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_bus),
        .i_cfg        (cfg_bus),
        .i_res        (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_idle       (chk_idle)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(negedge i_clk) begin
        res_bus.ready <= ready_pat[ready_pos];
        ready_pos <= ready_pos + 4'd1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic next_echo();
        if (echo_run == 0) begin
            echo_lvl = ~echo_lvl;
            echo_run = $urandom_range(1, span);
        end
        echo_run--;
        return ($urandom_range(0, 15) == 0) ? ~echo_lvl : echo_lvl;
    endfunction

    task automatic send_tick(input logic echo, input logic start);
        tick_bus.valid      <= 1'b1;
        tick_bus.echo_level <= echo;
        tick_bus.start_req  <= start;
        do @(posedge i_clk); while (tick_bus.ready !== 1'b1);
    endtask

    task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                             input logic [uer_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // with drain set, stop starting bursts and run until the ranger is back in idle
    task automatic pump_ticks(input int count, input bit drain);
        int burst;
        int sent;
        bit stop;
        burst = 0;
        sent = 0;
        stop = 1'b0;
        while (!stop) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                repeat ($urandom_range(0, gap_max)) begin
                    @(negedge i_clk);
                    tick_bus.valid <= 1'b0;
                end
            end
            @(negedge i_clk);
            stop = drain ? chk_idle : (sent >= count);
            if (stop) begin
                tick_bus.valid <= 1'b0;
            end else begin
                send_tick(next_echo(), drain ? 1'b0 : ($urandom_range(0, 3) == 0));
                sent++;
                burst--;
            end
        end
    endtask

    task automatic settle();
        while (!(chk_idle && pending == 0)) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] tmo;
        logic [15:0] trg;
        tick_bus.valid = 1'b0;
        tick_bus.echo_level = 1'b0;
        tick_bus.start_req = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        res_bus.ready = 1'b0;
        i_rst_n = 1'b0;
        echo_lvl = 1'b0;
        echo_run = 0;
        span = 4;
        gap_max = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(uer_pkg::REG_TIMEOUT, 16'd3);
        write_reg(uer_pkg::REG_TRIGGER, 16'd1);
        for (int i = 0; i < DIRECTED_LEN; i++) begin
            @(negedge i_clk);
            send_tick(DIR_ECHO[i], DIR_START[i]);
        end
        @(negedge i_clk);
        tick_bus.valid <= 1'b0;
        settle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    tmo = 16'd0;
                    trg = 16'd0;
                end
                1: begin
                    tmo = 16'd1;
                    trg = 16'd1;
                end
                2: begin
                    tmo = 16'hFFFF;
                    trg = 16'd255;
                end
                3: begin
                    tmo = uer_pkg::TIMEOUT_RST;
                    trg = 16'(uer_pkg::TRIGGER_RST);
                end
                4: begin
                    tmo = 16'($urandom_range(2, 60));
                    trg = 16'hA500 | 16'($urandom_range(2, 12));
                end
                default: begin
                    tmo = 16'($urandom_range(1, 60));
                    trg = 16'($urandom_range(1, 12));
                end
            endcase
            ready_pat <= (ph % 4 == 1) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            gap_max = (ph % 3 == 0) ? 0 : $urandom_range(2, 8);
            span = (tmo < 16'd40) ? int'(tmo) + 3 : 40;
            write_reg(uer_pkg::REG_TIMEOUT, tmo);
            write_reg(uer_pkg::REG_TRIGGER, trg);
            if (ph == 3) begin
                write_reg(REG_SPARE, 16'($urandom));
            end
            pump_ticks(PHASE_TICKS, 1'b0);
            pump_ticks(0, 1'b1);
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
